// File: rtl/text_console_cursor_engine_top_defines.svh
// ---------------------------------------------------------------------------
// text_console_cursor_engine_top_defines
// Assertion macros used by the console engine checker.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_TOP_DEFINES_SVH

// clocked assertion, masked while reset is high
`define TCCE_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define TCCE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/tcce_pkg.sv
// ---------------------------------------------------------------------------
// tcce_pkg
// Geometry constants, codes and types of the text console cursor engine.
// ---------------------------------------------------------------------------
package tcce_pkg;

   localparam int TOTAL_CELLS  = 16384;
   localparam int SCREEN_COLS  = 80;
   localparam int SCREEN_ROWS  = 25;
   localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;

   localparam int POS_W  = 14;
   localparam int CELL_W = $clog2(TOTAL_CELLS);
   localparam int COL_W  = $clog2(SCREEN_COLS);
   localparam int MEM_ROWS = TOTAL_CELLS / SCREEN_COLS + 1;
   localparam int ROW_W  = $clog2((MEM_ROWS > SCREEN_ROWS) ? MEM_ROWS : SCREEN_ROWS + 1);

   // first window row at which the window touches the end of memory
   localparam int END_ROW = (TOTAL_CELLS > SCREEN_CELLS) ?
      (TOTAL_CELLS - SCREEN_CELLS + SCREEN_COLS - 1) / SCREEN_COLS : 0;
   localparam int END_CELL = END_ROW * SCREEN_COLS;
   localparam int NEWLINE_LIMIT = TOTAL_CELLS - SCREEN_COLS;
   localparam int RESET_ROW = 5;
   localparam int RESET_CURSOR = RESET_ROW * SCREEN_COLS;
   localparam logic [7:0] RESET_COLOR = 8'd7;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] ACT_PUT_CHAR    = 2'd0;
   localparam logic [1:0] ACT_GOTO_XY     = 2'd1;
   localparam logic [1:0] ACT_SCROLL_UP   = 2'd2;
   localparam logic [1:0] ACT_SCROLL_DOWN = 2'd3;

   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_BLANK     = 8'd32;

   localparam logic [2:0] OP_PRINT       = 3'd0;
   localparam logic [2:0] OP_NEWLINE     = 3'd1;
   localparam logic [2:0] OP_BACKSPACE   = 3'd2;
   localparam logic [2:0] OP_GOTO        = 3'd3;
   localparam logic [2:0] OP_SCROLL_UP   = 3'd4;
   localparam logic [2:0] OP_SCROLL_DOWN = 3'd5;

   typedef struct packed {
      logic [2:0]        op;
      logic [7:0]        char_code;
      logic [CELL_W-1:0] goto_cell;
      logic [ROW_W-1:0]  goto_row;
      logic [COL_W-1:0]  goto_col;
   } cmd_type;

   typedef struct packed {
      logic has_data;
      logic has_room;
   } queue_status_type;

endpackage

// File: rtl/tcce_req_if.sv
// ---------------------------------------------------------------------------
// tcce_req_if
// Request channel: one console command word.
// ---------------------------------------------------------------------------
interface tcce_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        action;
   logic [7:0]        char_code;
   logic signed [7:0] column;
   logic signed [7:0] row;

   modport source (output valid, action, char_code, column, row, input ready);
   modport sink   (input valid, action, char_code, column, row, output ready);
endinterface

// File: rtl/tcce_rsp_if.sv
// ---------------------------------------------------------------------------
// tcce_rsp_if
// Response channel: cell write plus new cursor and window start.
// ---------------------------------------------------------------------------
interface tcce_rsp_if;
   import tcce_pkg::*;

   logic             valid;
   logic             ready;
   logic             write_enable;
   logic [POS_W-1:0] cell_index;
   logic [7:0]       cell_char;
   logic [7:0]       cell_attr;
   logic [POS_W-1:0] cursor_index;
   logic [POS_W-1:0] window_start;

   modport source (output valid, write_enable, cell_index, cell_char, cell_attr,
                   cursor_index, window_start, input ready);
   modport sink   (input valid, write_enable, cell_index, cell_char, cell_attr,
                   cursor_index, window_start, output ready);
endinterface

// File: rtl/tcce_queue.sv
// ---------------------------------------------------------------------------
// tcce_queue
// Short command queue between the decode front and the execute back.
// ---------------------------------------------------------------------------
module tcce_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  tcce_pkg::cmd_type           push_cmd,
   input  logic                        pop,
   output tcce_pkg::cmd_type           head_cmd,
   output tcce_pkg::queue_status_type  status
);
   import tcce_pkg::*;

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd        = entry_ff[rd_ptr_ff];
   assign status.has_data = (count_ff != '0);
   assign status.has_room = (count_ff != QCNT_W'(QUEUE_DEPTH));

endmodule

// File: rtl/tcce_front.sv
// ---------------------------------------------------------------------------
// tcce_front
// Accepts request words, classifies them and clamps goto coordinates.
// ---------------------------------------------------------------------------
module tcce_front (
   tcce_req_if.sink                   req_chan,
   input  tcce_pkg::queue_status_type status,
   output logic                       push,
   output tcce_pkg::cmd_type          push_cmd
);
   import tcce_pkg::*;

   localparam logic signed [9:0] COL_MAX = 10'(SCREEN_COLS - 1);
   localparam logic signed [9:0] ROW_MAX = 10'(SCREEN_ROWS - 1);

   logic signed [9:0] col_ext;
   logic signed [9:0] row_ext;
   logic [COL_W-1:0]  col_clamped;
   logic [ROW_W-1:0]  row_clamped;

   assign col_ext = {{2{req_chan.column[7]}}, req_chan.column};
   assign row_ext = {{2{req_chan.row[7]}}, req_chan.row};

   always_comb begin
      priority if (col_ext < 10'sd0) begin
         col_clamped = '0;
      end else if (col_ext > COL_MAX) begin
         col_clamped = COL_W'(SCREEN_COLS - 1);
      end else begin
         col_clamped = COL_W'(col_ext);
      end
      priority if (row_ext < 10'sd0) begin
         row_clamped = '0;
      end else if (row_ext > ROW_MAX) begin
         row_clamped = ROW_W'(SCREEN_ROWS - 1);
      end else begin
         row_clamped = ROW_W'(row_ext);
      end
   end

   always_comb begin
      push_cmd.char_code = req_chan.char_code;
      push_cmd.goto_col  = col_clamped;
      push_cmd.goto_row  = row_clamped;
      push_cmd.goto_cell = CELL_W'(row_clamped * SCREEN_COLS + col_clamped);
      unique case (req_chan.action)
         ACT_PUT_CHAR: begin
            priority if (req_chan.char_code == CH_NEWLINE) begin
               push_cmd.op = OP_NEWLINE;
            end else if (req_chan.char_code == CH_BACKSPACE) begin
               push_cmd.op = OP_BACKSPACE;
            end else begin
               push_cmd.op = OP_PRINT;
            end
         end
         ACT_GOTO_XY:   push_cmd.op = OP_GOTO;
         ACT_SCROLL_UP: push_cmd.op = OP_SCROLL_UP;
         default:       push_cmd.op = OP_SCROLL_DOWN;
      endcase
   end

   assign req_chan.ready = status.has_room;
   assign push           = req_chan.valid && status.has_room;

endmodule

// File: rtl/tcce_back.sv
// ---------------------------------------------------------------------------
// tcce_back
// Executes queued commands against cursor and window state, holds the
// color register and the response output register.
// ---------------------------------------------------------------------------
module tcce_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [7:0]                 csr_write_data,
   input  tcce_pkg::cmd_type          head_cmd,
   input  tcce_pkg::queue_status_type status,
   output logic                       pop,
   tcce_rsp_if.source                 rsp_chan
);
   import tcce_pkg::*;

   logic [7:0]        color_ff;
   logic [CELL_W-1:0] cur_ff, cur_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  ds_row_ff, ds_row_in, ds_row_step;
   logic [CELL_W-1:0] ds_cell_ff, ds_cell_in, ds_cell_step;

   logic              we_in;
   logic [CELL_W-1:0] idx_in;
   logic [7:0]        ch_in, attr_in;
   logic              is_put;
   logic [ROW_W:0]    row_limit;
   logic [ROW_W:0]    row_target;

   logic              out_valid_ff;
   logic              out_we_ff;
   logic [POS_W-1:0]  out_idx_ff, out_cursor_ff, out_window_ff;
   logic [7:0]        out_char_ff, out_attr_ff;
   logic              advance;

   assign advance = !out_valid_ff || rsp_chan.ready;
   assign pop     = status.has_data && advance;

   always_comb begin
      cur_in       = cur_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      ds_row_step  = ds_row_ff;
      ds_cell_step = ds_cell_ff;
      we_in        = 1'b0;
      idx_in       = '0;
      ch_in        = '0;
      attr_in      = '0;
      is_put       = 1'b0;
      unique case (head_cmd.op)
         OP_PRINT: begin
            is_put = 1'b1;
            if (cur_ff < CELL_W'(TOTAL_CELLS - 1)) begin
               we_in   = 1'b1;
               idx_in  = cur_ff;
               ch_in   = head_cmd.char_code;
               attr_in = color_ff;
               cur_in  = cur_ff + 1'b1;
               if (col_ff == COL_W'(SCREEN_COLS - 1)) begin
                  col_in = '0;
                  row_in = row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         OP_NEWLINE: begin
            is_put = 1'b1;
            if (cur_ff < CELL_W'(NEWLINE_LIMIT)) begin
               cur_in = cur_ff - CELL_W'(col_ff) + CELL_W'(SCREEN_COLS);
               col_in = '0;
               row_in = row_ff + 1'b1;
            end
         end
         OP_BACKSPACE: begin
            is_put = 1'b1;
            if (cur_ff != '0) begin
               cur_in  = cur_ff - 1'b1;
               we_in   = 1'b1;
               idx_in  = cur_ff - 1'b1;
               ch_in   = CH_BLANK;
               attr_in = color_ff;
               if (col_ff == '0) begin
                  col_in = COL_W'(SCREEN_COLS - 1);
                  row_in = row_ff - 1'b1;
               end else begin
                  col_in = col_ff - 1'b1;
               end
            end
         end
         OP_GOTO: begin
            cur_in = head_cmd.goto_cell;
            row_in = head_cmd.goto_row;
            col_in = head_cmd.goto_col;
         end
         OP_SCROLL_UP: begin
            if (ds_row_ff != '0) begin
               ds_row_step  = ds_row_ff - 1'b1;
               ds_cell_step = ds_cell_ff - CELL_W'(SCREEN_COLS);
            end
         end
         OP_SCROLL_DOWN: begin
            if (ds_row_ff < ROW_W'(END_ROW)) begin
               ds_row_step  = ds_row_ff + 1'b1;
               ds_cell_step = ds_cell_ff + CELL_W'(SCREEN_COLS);
            end
         end
         default: begin
         end
      endcase
   end

   // follow the cursor down by whole lines, stopping at the end of memory
   assign row_limit  = {1'b0, ds_row_ff} + (ROW_W+1)'(SCREEN_ROWS);
   assign row_target = {1'b0, row_in} - (ROW_W+1)'(SCREEN_ROWS - 1);

   always_comb begin
      ds_row_in  = ds_row_step;
      ds_cell_in = ds_cell_step;
      if (is_put && ({1'b0, row_in} >= row_limit) && (ds_row_ff < ROW_W'(END_ROW))) begin
         if (row_target >= (ROW_W+1)'(END_ROW)) begin
            ds_row_in  = ROW_W'(END_ROW);
            ds_cell_in = CELL_W'(END_CELL);
         end else begin
            ds_row_in  = ROW_W'(row_target);
            ds_cell_in = cur_in - CELL_W'(col_in) - CELL_W'((SCREEN_ROWS - 1) * SCREEN_COLS);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff     <= RESET_COLOR;
         cur_ff       <= CELL_W'(RESET_CURSOR);
         row_ff       <= ROW_W'(RESET_ROW);
         col_ff       <= '0;
         ds_row_ff    <= '0;
         ds_cell_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            color_ff <= csr_write_data;
         end
         if (pop) begin
            cur_ff     <= cur_in;
            row_ff     <= row_in;
            col_ff     <= col_in;
            ds_row_ff  <= ds_row_in;
            ds_cell_ff <= ds_cell_in;
         end
         if (advance) begin
            out_valid_ff <= status.has_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_we_ff     <= we_in;
         out_idx_ff    <= POS_W'(idx_in);
         out_char_ff   <= ch_in;
         out_attr_ff   <= attr_in;
         out_cursor_ff <= POS_W'(cur_in);
         out_window_ff <= POS_W'(ds_cell_in);
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.write_enable = out_we_ff;
   assign rsp_chan.cell_index   = out_idx_ff;
   assign rsp_chan.cell_char    = out_char_ff;
   assign rsp_chan.cell_attr    = out_attr_ff;
   assign rsp_chan.cursor_index = out_cursor_ff;
   assign rsp_chan.window_start = out_window_ff;

endmodule

// File: rtl/text_console_cursor_engine_top.sv
// A request word goes into the command queue; when it reaches the queue head it is
// executed and its response word is held in the response register until taken.
// Throughput: one word per cycle while responses are taken; the execute stage
// updates cursor and window state behind a two-entry command queue.
// Reset (synchronous): cursor at the start of row five, window start zero,
// color 7, queue and response register empty.
// ---------------------------------------------------------------------------
// text_console_cursor_engine_top
// Text console cursor engine: decode front, command queue, execute back.
// ---------------------------------------------------------------------------
module text_console_cursor_engine_top (
   input  logic       clock,
   input  logic       reset,
   tcce_req_if.sink   req_chan,
   tcce_rsp_if.source rsp_chan,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);
   import tcce_pkg::*;

   logic             push;
   logic             pop;
   cmd_type          push_cmd;
   cmd_type          head_cmd;
   queue_status_type status;

   tcce_front u_front (
      .req_chan (req_chan),
      .status   (status),
      .push     (push),
      .push_cmd (push_cmd)
   );

   tcce_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (status)
   );

   tcce_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .head_cmd         (head_cmd),
      .status           (status),
      .pop              (pop),
      .rsp_chan         (rsp_chan)
   );

endmodule

// File: rtl/tcce_chk.sv
// ---------------------------------------------------------------------------
// tcce_chk
// Port-level checks of the console engine response channel.
// ---------------------------------------------------------------------------
`include "text_console_cursor_engine_top_defines.svh"

module tcce_chk (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_write_enable,
   input logic [tcce_pkg::POS_W-1:0] rsp_cell_index,
   input logic [7:0]                 rsp_cell_char,
   input logic [7:0]                 rsp_cell_attr,
   input logic [tcce_pkg::POS_W-1:0] rsp_cursor_index,
   input logic [tcce_pkg::POS_W-1:0] rsp_window_start
);
   import tcce_pkg::*;

   `TCCE_ASSERT_ALWAYS(a_idle_after_reset, clock, (reset |=> !rsp_valid),
      "response valid right after reset")

   `TCCE_ASSERT_CLK(a_no_write_zero, clock, reset,
      ((rsp_valid && !rsp_write_enable) |->
       ((rsp_cell_index == '0) && (rsp_cell_char == '0) && (rsp_cell_attr == '0))),
      "cell fields nonzero without a write")

   `TCCE_ASSERT_CLK(a_write_moves_cursor, clock, reset,
      ((rsp_valid && rsp_write_enable) |->
       ((rsp_cursor_index == POS_W'(rsp_cell_index + 1'b1)) ||
        (rsp_cursor_index == rsp_cell_index))),
      "cursor not next to written cell")

   `TCCE_ASSERT_CLK(a_stall_holds, clock, reset,
      ((rsp_valid && !rsp_ready) |=> (rsp_valid && $stable({rsp_write_enable,
       rsp_cell_index, rsp_cell_char, rsp_cell_attr, rsp_cursor_index, rsp_window_start}))),
      "stalled response word changed")

endmodule

bind text_console_cursor_engine_top tcce_chk u_chk (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_write_enable (rsp_chan.write_enable),
   .rsp_cell_index   (rsp_chan.cell_index),
   .rsp_cell_char    (rsp_chan.cell_char),
   .rsp_cell_attr    (rsp_chan.cell_attr),
   .rsp_cursor_index (rsp_chan.cursor_index),
   .rsp_window_start (rsp_chan.window_start)
);
